@@ rtl/midpoint_ellipse_span_generator_top_defines.svh @@
// Assertion macros for the midpoint ellipse span generator.
`ifndef MIDPOINT_ELLIPSE_SPAN_GENERATOR_TOP_DEFINES_SVH
`define MIDPOINT_ELLIPSE_SPAN_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define MESG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define MESG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MESG_ASSERT_ALWAYS(label, cond, msg)
`define MESG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/mesg_pkg.sv @@
// Shared widths, codes and helpers of the ellipse span generator.
`default_nettype none
package mesg_pkg;

  localparam int COORD_BITS = 16;
  localparam int BOX_W      = 16;
  localparam int POS_W      = COORD_BITS + 1;
  localparam int CTR_W      = COORD_BITS + 2;
  localparam int RSQ_W      = 2 * COORD_BITS - 1;
  localparam int ACC_W      = 3 * COORD_BITS;
  localparam int DEC_W      = 64;
  localparam int ROW_W      = 18;
  localparam int LEN_W      = 17;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_TRUNC = 5'b00100,
    ST_STEP  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // products computed on the shared multiplier, in sequence order
  typedef enum logic [2:0] {
    OP_RX2,
    OP_RY2,
    OP_T,
    OP_HH,
    OP_RYH,
    OP_YY,
    OP_RXY,
    OP_RXRY
  } mul_op_t;

  // quarter units to integer, truncating toward zero
  function automatic logic signed [DEC_W-1:0] qtrunc(input logic signed [DEC_W-1:0] q);
    logic signed [DEC_W-1:0] adj;
    adj = q + DEC_W'({q[DEC_W-1], q[DEC_W-1]});
    return adj >>> 2;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mesg_if.sv @@
// Valid/ready channels carrying the command beat and the span beat.
`default_nettype none
interface mesg_req_if import mesg_pkg::*;;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [BOX_W-1:0] box_left;
  logic [BOX_W-1:0] box_top;
  logic [BOX_W-1:0] box_right;
  logic [BOX_W-1:0] box_bottom;

  modport source (output valid, cmd, box_left, box_top, box_right, box_bottom,
                  input ready);
  modport sink   (input valid, cmd, box_left, box_top, box_right, box_bottom,
                  output ready);
endinterface

interface mesg_rsp_if import mesg_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [ROW_W-1:0] row_above;
  logic signed [ROW_W-1:0] row_below;
  logic signed [ROW_W-1:0] span_start;
  logic [LEN_W-1:0]        span_length;
  logic                    finished;

  modport source (output valid, row_above, row_below, span_start, span_length, finished,
                  input ready);
  modport sink   (input valid, row_above, row_below, span_start, span_length, finished,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/mesg_mul.sv @@
// Shift-add multiplier, 64-bit wrapping product, one multiplier bit per cycle.
`default_nettype none
module mesg_mul import mesg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEC_W-1:0] a,
  input  logic [DEC_W-1:0] b,
  output logic             done,
  output logic [DEC_W-1:0] product
);

  logic             run;
  logic [DEC_W-1:0] ma;
  logic [DEC_W-1:0] mb;
  logic [DEC_W-1:0] acc;

  // stops as soon as the remaining multiplier bits are all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      ma  <= a;
      mb  <= b;
      acc <= '0;
    end else if (run) begin
      if (mb == '0) begin
        run <= 1'b0;
      end else begin
        if (mb[0]) begin
          acc <= acc + ma;
        end
        ma <= ma << 1;
        mb <= mb >> 1;
      end
    end
  end

  assign done    = run && (mb == '0);
  assign product = acc;

endmodule
`default_nettype wire

@@ rtl/midpoint_ellipse_span_generator_top.sv @@
// Top level of the midpoint ellipse span generator.
// Filled ellipse as span pairs, one result beat per command beat. A plain advance
// is accepted, then the result beat is offered. A start beat and the advance that
// crosses into region 2 run a short sequence of products on one shift-add
// multiplier that retires one multiplier bit per cycle, so the time that each
// product takes grows with the bit length of its second operand. The command side
// is ready only while the block is idle and no result beat is offered.
`default_nettype none
`include "midpoint_ellipse_span_generator_top_defines.svh"
module midpoint_ellipse_span_generator_top import mesg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mesg_req_if.sink    req,
  mesg_rsp_if.source  rsp
);

  state_t                  state;
  mul_op_t                 op;
  logic                    launch;
  logic                    all_done;
  logic                    region_two;
  logic                    fin;
  logic signed [CTR_W-1:0] centre_col;
  logic signed [CTR_W-1:0] centre_row;
  logic signed [POS_W-1:0] rad_x;
  logic [RSQ_W-1:0]        rx_squared;
  logic [RSQ_W-1:0]        ry_squared;
  logic signed [POS_W-1:0] cur_x;
  logic signed [POS_W-1:0] cur_y;
  logic signed [ACC_W-1:0] acc_px;
  logic signed [ACC_W-1:0] acc_py;
  logic signed [DEC_W-1:0] decision;
  logic signed [DEC_W-1:0] dsum;
  logic [DEC_W-1:0]        tmp;

  // box decode
  logic [COORD_BITS-1:0]   bl, bt, br, bb;
  logic signed [POS_W-1:0] dx, dy, dxr, dyr, rx_new, ry_new;

  // iteration datapath
  logic signed [DEC_W-1:0] px_e, py_e, rx2_e, ry2_e;
  logic signed [DEC_W-1:0] px_inc, py_dec;
  logic signed [DEC_W-1:0] d_r1a, d_r1b, d_r2a, d_r2b;

  // multiplier operands
  logic signed [DEC_W-1:0] rx_e, ry_e, ym_e, h_e;
  logic [DEC_W-1:0]        mul_a, mul_b;
  logic                    mul_done;
  logic [DEC_W-1:0]        mul_p;
  logic                    start_go, adv_go;

  assign start_go = (state == ST_IDLE) && req.valid && !req.cmd;
  assign adv_go   = ((state == ST_IDLE) && req.valid && req.cmd) || (state == ST_STEP);

  always_comb begin
    bl  = COORD_BITS'(req.box_left);
    bt  = COORD_BITS'(req.box_top);
    br  = COORD_BITS'(req.box_right);
    bb  = COORD_BITS'(req.box_bottom);
    dx  = POS_W'(br) - POS_W'(bl);
    dy  = POS_W'(bb) - POS_W'(bt);
    // halve toward zero
    dxr = dx + POS_W'(dx[POS_W-1]);
    dyr = dy + POS_W'(dy[POS_W-1]);
    rx_new = dxr >>> 1;
    ry_new = dyr >>> 1;
  end

  always_comb begin
    px_e   = DEC_W'(acc_px);
    py_e   = DEC_W'(acc_py);
    rx2_e  = DEC_W'(rx_squared);
    ry2_e  = DEC_W'(ry_squared);
    px_inc = px_e + (ry2_e <<< 1);
    py_dec = py_e - (rx2_e <<< 1);
    d_r1a  = decision + px_inc + ry2_e;
    d_r1b  = d_r1a - py_dec;
    d_r2a  = decision + rx2_e - py_dec;
    d_r2b  = d_r2a + px_inc;
  end

  always_comb begin
    rx_e = DEC_W'(rad_x);
    ry_e = DEC_W'(cur_y);
    ym_e = DEC_W'(cur_y) - DEC_W'(1);
    h_e  = (DEC_W'(cur_x) <<< 1) + DEC_W'(1);
    case (op)
      OP_RX2: begin
        mul_a = (rx_e < 0) ? -rx_e : rx_e;
        mul_b = mul_a;
      end
      OP_RY2: begin
        mul_a = (ry_e < 0) ? -ry_e : ry_e;
        mul_b = mul_a;
      end
      OP_T: begin
        mul_a = rx2_e;
        mul_b = ry_e;
      end
      OP_HH: begin
        mul_a = h_e;
        mul_b = h_e;
      end
      OP_RYH: begin
        mul_a = tmp;
        mul_b = ry2_e;
      end
      OP_YY: begin
        mul_a = (ym_e < 0) ? -ym_e : ym_e;
        mul_b = mul_a;
      end
      OP_RXY: begin
        mul_a = tmp;
        mul_b = rx2_e;
      end
      OP_RXRY: begin
        mul_a = rx2_e;
        mul_b = ry2_e;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mesg_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (launch),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      launch     <= 1'b0;
      all_done   <= 1'b1;
      region_two <= 1'b0;
      fin        <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        ST_IDLE, ST_STEP: begin
          if (start_go) begin
            centre_col <= CTR_W'(bl) + CTR_W'(rx_new);
            centre_row <= CTR_W'(bt) + CTR_W'(ry_new);
            rad_x      <= rx_new;
            cur_x      <= '0;
            cur_y      <= ry_new;
            acc_px     <= '0;
            region_two <= 1'b0;
            all_done   <= 1'b0;
            op         <= OP_RX2;
            launch     <= 1'b1;
            state      <= ST_MUL;
          end else if (adv_go) begin
            if (all_done) begin
              fin   <= 1'b1;
              state <= ST_OUT;
            end else if (!region_two && (acc_px < acc_py)) begin
              cur_x  <= cur_x + POS_W'(1);
              acc_px <= ACC_W'(px_inc);
              if (decision < 0) begin
                decision <= d_r1a;
              end else begin
                cur_y    <= cur_y - POS_W'(1);
                acc_py   <= ACC_W'(py_dec);
                decision <= d_r1b;
              end
              fin   <= 1'b0;
              state <= ST_OUT;
            end else if (!region_two) begin
              // region crossing: rebuild the decision, then take the region 2 step or finish
              region_two <= 1'b1;
              op         <= OP_HH;
              launch     <= 1'b1;
              state      <= ST_MUL;
            end else if (cur_y > 0) begin
              cur_y  <= cur_y - POS_W'(1);
              acc_py <= ACC_W'(py_dec);
              if (decision > 0) begin
                decision <= d_r2a;
              end else begin
                cur_x    <= cur_x + POS_W'(1);
                acc_px   <= ACC_W'(px_inc);
                decision <= d_r2b;
              end
              fin   <= 1'b0;
              state <= ST_OUT;
            end else begin
              all_done <= 1'b1;
              fin      <= 1'b1;
              state    <= ST_OUT;
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            case (op)
              OP_RX2: begin
                rx_squared <= RSQ_W'(mul_p);
                op         <= OP_RY2;
                launch     <= 1'b1;
              end
              OP_RY2: begin
                ry_squared <= RSQ_W'(mul_p);
                dsum       <= (mul_p << 2) + rx2_e + DEC_W'(2);
                op         <= OP_T;
                launch     <= 1'b1;
              end
              OP_T: begin
                acc_py <= ACC_W'(mul_p << 1);
                dsum   <= dsum - (mul_p << 2);
                state  <= ST_TRUNC;
              end
              OP_HH: begin
                tmp    <= mul_p;
                op     <= OP_RYH;
                launch <= 1'b1;
              end
              OP_RYH: begin
                dsum   <= mul_p + DEC_W'(2);
                op     <= OP_YY;
                launch <= 1'b1;
              end
              OP_YY: begin
                tmp    <= mul_p;
                op     <= OP_RXY;
                launch <= 1'b1;
              end
              OP_RXY: begin
                dsum   <= dsum + (mul_p << 2);
                op     <= OP_RXRY;
                launch <= 1'b1;
              end
              OP_RXRY: begin
                dsum  <= dsum - (mul_p << 2);
                state <= ST_TRUNC;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_TRUNC: begin
          decision <= qtrunc(dsum);
          fin      <= 1'b0;
          state    <= region_two ? ST_STEP : ST_OUT;
        end
        ST_OUT: begin
          if (rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);

  // result beat is read straight from the held state
  assign rsp.valid       = (state == ST_OUT);
  assign rsp.finished    = fin;
  assign rsp.row_above   = fin ? '0 : ROW_W'(centre_row) - ROW_W'(cur_y);
  assign rsp.row_below   = fin ? '0 : ROW_W'(centre_row) + ROW_W'(cur_y);
  assign rsp.span_start  = fin ? '0 : ROW_W'(centre_col) - ROW_W'(cur_x);
  assign rsp.span_length = fin ? '0 : LEN_W'({cur_x, 1'b0});

  `MESG_ASSERT_ALWAYS(a_one_side_open, !(req.ready && rsp.valid), "command and result open together")
  `MESG_ASSERT_ALWAYS(a_mul_in_seq, !mul_done || (state == ST_MUL), "multiplier done outside sequence")
  `MESG_ASSERT_ALWAYS(a_fin_zero, !(rsp.valid && rsp.finished) || (rsp.span_length == '0 && rsp.row_above == '0), "finished beat with span data")
  `MESG_ASSERT_NEXT(a_ready_after_beat, rsp.valid && rsp.ready, req.ready, "not ready after result beat")

endmodule
`default_nettype wire
